[design/amc_pkg.sv]
package amc_pkg;

   // operation codes of an input item
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_BUILD = 2'd2;
   localparam logic [1:0] OP_SCAN  = 2'd3;

   // status codes of a result item
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_STATES_FULL = 2'd1;
   localparam logic [1:0] STATUS_PATS_FULL   = 2'd2;

   // last byte value of a row sweep
   localparam logic [7:0] BYTE_LAST = 8'hFF;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CHK,
      ST_ADD_MWR,
      ST_BR_RD,
      ST_BR_CHK,
      ST_BQ_RD,
      ST_BQ_S,
      ST_BQ_F,
      ST_BG_RD,
      ST_BG_CHK,
      ST_ADV_RD,
      ST_ADV_CHK,
      ST_ADV_FL,
      ST_BL_M1,
      ST_BL_M2,
      ST_SC_M,
      ST_DONE
   } state_type;

endpackage

[design/multi_pattern_byte_matcher.sv]
// one item at a time: a new item is taken only in the idle state, and a result waits until
// the output register is free or rsp_ready takes the one it holds; all table reads go
// through the single read port of each memory.
// reset runs a clearing pass over the goto, failure and mask memories
// before the first item is accepted; a clear item runs the same pass.
module multi_pattern_byte_matcher #(
   parameter int MAX_STATES    = 256,
   parameter int MAX_PATTERNS  = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        req_pattern_end,
   input  logic        req_block_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_match_mask,
   output logic [31:0] rsp_end_position
);

   import amc_pkg::*;

   localparam int SB  = $clog2(MAX_STATES);
   localparam int SUW = $clog2(MAX_STATES + 1);
   localparam int PUW = $clog2(MAX_PATTERNS + 1);
   localparam int GAW = SB + 8;
   localparam int GD  = MAX_STATES * 256;
   localparam int MW  = MAX_PATTERNS;
   localparam int PB  = POSITION_BITS;

   state_type state_ff, state_in;
   logic [GAW-1:0] cnt_ff, cnt_in;
   logic           clr_resp_ff, clr_resp_in;
   logic [7:0]     dbyte_ff, dbyte_in;
   logic           last_ff, last_in;
   logic           scan_ff, scan_in;
   logic [SUW-1:0] su_ff, su_in;
   logic [PUW-1:0] pu_ff, pu_in;
   logic [SB-1:0]  cursor_ff, cursor_in;
   logic [SB-1:0]  sstate_ff, sstate_in;
   logic [PB-1:0]  pos_ff, pos_in;
   logic [SUW-1:0] head_ff, head_in;
   logic [SUW-1:0] tail_ff, tail_in;
   logic [SB-1:0]  s_ff, s_in;
   logic [SB-1:0]  fs_ff, fs_in;
   logic [7:0]     bcnt_ff, bcnt_in;
   logic [SB-1:0]  c_ff, c_in;
   logic [SB-1:0]  st_ff, st_in;
   logic [SUW-1:0] steps_ff, steps_in;
   logic [MW-1:0]  mf_ff, mf_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [MW-1:0]  res_mask_ff, res_mask_in;
   logic [PB-1:0]  res_pos_ff, res_pos_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [15:0]    rsp_mask_ff, rsp_mask_in;
   logic [31:0]    rsp_pos_ff, rsp_pos_in;

   // memory ports
   logic           g_we;
   logic [GAW-1:0] g_waddr, g_raddr;
   logic [SB:0]    g_wdata, g_rdata;
   logic           f_we;
   logic [SB-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
   logic           m_we;
   logic [SB-1:0]  m_waddr, m_raddr;
   logic [MW-1:0]  m_wdata, m_rdata;
   logic           q_we;
   logic [SB-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

   logic           ent_valid;
   logic [SB-1:0]  ent_tgt;
   logic [7:0]     walk_byte;
   logic [SB-1:0]  add_t;
   logic [SB-1:0]  adv_f;
   logic [63:0]    mask_wide;
   logic [63:0]    pos_wide;
   logic           req_fire;

   assign ent_valid = g_rdata[SB];
   assign ent_tgt   = g_rdata[SB-1:0];
   assign walk_byte = scan_ff ? dbyte_ff : bcnt_ff;
   assign add_t     = ent_valid ? ent_tgt : su_ff[SB-1:0];
   assign adv_f     = ent_valid ? ent_tgt : '0;
   assign mask_wide = 64'(res_mask_ff);
   assign pos_wide  = 64'(res_pos_ff);
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;

   amc_ram #(.WIDTH(SB + 1), .DEPTH(GD)) u_goto (
      .clock(clock), .wr_en(g_we), .wr_addr(g_waddr), .wr_data(g_wdata),
      .rd_addr(g_raddr), .rd_data(g_rdata)
   );

   amc_ram #(.WIDTH(SB), .DEPTH(MAX_STATES)) u_fail (
      .clock(clock), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
      .rd_addr(f_raddr), .rd_data(f_rdata)
   );

   amc_ram #(.WIDTH(MW), .DEPTH(MAX_STATES)) u_mask (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_addr(m_raddr), .rd_data(m_rdata)
   );

   amc_ram #(.WIDTH(SB), .DEPTH(MAX_STATES)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
      .rd_addr(q_raddr), .rd_data(q_rdata)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dbyte_ff      <= dbyte_in;
      last_ff       <= last_in;
      scan_ff       <= scan_in;
      su_ff         <= su_in;
      pu_ff         <= pu_in;
      cursor_ff     <= cursor_in;
      sstate_ff     <= sstate_in;
      pos_ff        <= pos_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      s_ff          <= s_in;
      fs_ff         <= fs_in;
      bcnt_ff       <= bcnt_in;
      c_ff          <= c_in;
      st_ff         <= st_in;
      steps_ff      <= steps_in;
      mf_ff         <= mf_in;
      res_status_ff <= res_status_in;
      res_mask_ff   <= res_mask_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_resp_in   = clr_resp_ff;
      dbyte_in      = dbyte_ff;
      last_in       = last_ff;
      scan_in       = scan_ff;
      su_in         = su_ff;
      pu_in         = pu_ff;
      cursor_in     = cursor_ff;
      sstate_in     = sstate_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      s_in          = s_ff;
      fs_in         = fs_ff;
      bcnt_in       = bcnt_ff;
      c_in          = c_ff;
      st_in         = st_ff;
      steps_in      = steps_ff;
      mf_in         = mf_ff;
      res_status_in = res_status_ff;
      res_mask_in   = res_mask_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_pos_in    = rsp_pos_ff;

      g_we    = 1'b0;
      g_waddr = {cursor_ff, dbyte_ff};
      g_wdata = {1'b1, add_t};
      g_raddr = {st_ff, walk_byte};
      f_we    = 1'b0;
      f_waddr = c_ff;
      f_wdata = adv_f;
      f_raddr = st_ff;
      m_we    = 1'b0;
      m_waddr = c_ff;
      m_wdata = m_rdata | mf_ff;
      m_raddr = adv_f;
      q_we    = 1'b0;
      q_waddr = tail_ff[SB-1:0];
      q_wdata = ent_tgt;
      q_raddr = head_ff[SB-1:0];

      case (state_ff)
         // clearing pass over the goto, failure and mask tables
         ST_CLEAR: begin
            g_we    = 1'b1;
            g_waddr = cnt_ff;
            g_wdata = '0;
            f_we    = 1'b1;
            f_waddr = cnt_ff[GAW-1:8];
            f_wdata = '0;
            m_we    = 1'b1;
            m_waddr = cnt_ff[GAW-1:8];
            m_wdata = '0;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == GAW'(GD - 1)) begin
               cnt_in    = '0;
               su_in     = SUW'(1);
               pu_in     = '0;
               cursor_in = '0;
               sstate_in = '0;
               pos_in    = '0;
               state_in  = clr_resp_ff ? ST_DONE : ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               dbyte_in      = req_data_byte;
               last_in       = req_pattern_end;
               scan_in       = 1'b0;
               res_status_in = STATUS_OK;
               res_mask_in   = '0;
               res_pos_in    = '0;
               case (req_operation)
                  OP_CLEAR: begin
                     clr_resp_in = 1'b1;
                     cnt_in      = '0;
                     state_in    = ST_CLEAR;
                  end
                  OP_ADD: begin
                     state_in = ST_ADD_RD;
                  end
                  OP_BUILD: begin
                     bcnt_in  = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = ST_BR_RD;
                  end
                  default: begin
                     scan_in  = 1'b1;
                     steps_in = '0;
                     if (req_block_start) begin
                        st_in  = '0;
                        pos_in = '0;
                     end else begin
                        st_in = sstate_ff;
                     end
                     state_in = ST_ADV_RD;
                  end
               endcase
            end
         end

         // insert one pattern byte
         ST_ADD_RD: begin
            g_raddr  = {cursor_ff, dbyte_ff};
            state_in = ST_ADD_CHK;
         end

         ST_ADD_CHK: begin
            m_raddr = add_t;
            if (pu_ff >= PUW'(MAX_PATTERNS)) begin
               res_status_in = STATUS_PATS_FULL;
               if (last_ff) begin
                  cursor_in = '0;
               end
               state_in = ST_DONE;
            end else if (!ent_valid && su_ff >= SUW'(MAX_STATES)) begin
               res_status_in = STATUS_STATES_FULL;
               if (last_ff) begin
                  cursor_in = '0;
               end
               state_in = ST_DONE;
            end else begin
               if (!ent_valid) begin
                  g_we  = 1'b1;
                  su_in = su_ff + 1'b1;
               end
               if (last_ff) begin
                  c_in     = add_t;
                  state_in = ST_ADD_MWR;
               end else begin
                  cursor_in = add_t;
                  state_in  = ST_DONE;
               end
            end
         end

         ST_ADD_MWR: begin
            m_we      = 1'b1;
            m_wdata   = m_rdata | (MW'(1) << pu_ff);
            pu_in     = pu_ff + 1'b1;
            cursor_in = '0;
            state_in  = ST_DONE;
         end

         // build: children of the root first
         ST_BR_RD: begin
            g_raddr  = {SB'(0), bcnt_ff};
            state_in = ST_BR_CHK;
         end

         ST_BR_CHK: begin
            if (ent_valid && tail_ff < SUW'(MAX_STATES)) begin
               f_we    = 1'b1;
               f_waddr = ent_tgt;
               f_wdata = '0;
               q_we    = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            bcnt_in  = bcnt_ff + 1'b1;
            state_in = (bcnt_ff == BYTE_LAST) ? ST_BQ_RD : ST_BR_RD;
         end

         // dequeue the next state of the breadth-first walk
         ST_BQ_RD: begin
            if (head_ff < tail_ff) begin
               head_in  = head_ff + 1'b1;
               state_in = ST_BQ_S;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_BQ_S: begin
            s_in     = q_rdata;
            f_raddr  = q_rdata;
            bcnt_in  = '0;
            state_in = ST_BQ_F;
         end

         ST_BQ_F: begin
            fs_in    = f_rdata;
            state_in = ST_BG_RD;
         end

         ST_BG_RD: begin
            g_raddr  = {s_ff, bcnt_ff};
            state_in = ST_BG_CHK;
         end

         ST_BG_CHK: begin
            if (ent_valid) begin
               c_in = ent_tgt;
               if (tail_ff < SUW'(MAX_STATES)) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
               st_in    = fs_ff;
               steps_in = '0;
               state_in = ST_ADV_RD;
            end else begin
               bcnt_in  = bcnt_ff + 1'b1;
               state_in = (bcnt_ff == BYTE_LAST) ? ST_BQ_RD : ST_BG_RD;
            end
         end

         // shared failure walk for scan and build
         ST_ADV_RD: begin
            state_in = ST_ADV_CHK;
         end

         ST_ADV_CHK: begin
            if (ent_valid || st_ff == '0) begin
               if (scan_ff) begin
                  sstate_in = adv_f;
                  state_in  = ST_SC_M;
               end else begin
                  f_we     = 1'b1;
                  state_in = ST_BL_M1;
               end
            end else if (steps_ff >= SUW'(MAX_STATES)) begin
               st_in    = '0;
               state_in = ST_ADV_RD;
            end else begin
               state_in = ST_ADV_FL;
            end
         end

         ST_ADV_FL: begin
            st_in    = f_rdata;
            steps_in = steps_ff + 1'b1;
            state_in = ST_ADV_RD;
         end

         // merge the failure target's mask into the child
         ST_BL_M1: begin
            mf_in    = m_rdata;
            m_raddr  = c_ff;
            state_in = ST_BL_M2;
         end

         ST_BL_M2: begin
            m_we     = 1'b1;
            bcnt_in  = bcnt_ff + 1'b1;
            state_in = (bcnt_ff == BYTE_LAST) ? ST_BQ_RD : ST_BG_RD;
         end

         ST_SC_M: begin
            res_mask_in = m_rdata;
            res_pos_in  = pos_ff;
            pos_in      = pos_ff + 1'b1;
            state_in    = ST_DONE;
         end

         // hand the item to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_mask_in   = mask_wide[15:0];
               rsp_pos_in    = pos_wide[31:0];
               clr_resp_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_match_mask   = rsp_mask_ff;
   assign rsp_end_position = rsp_pos_ff;

endmodule

[design/amc_ram.sv]
module amc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
